// ===== rtl/core/emv_pkg.sv =====
package emv_pkg;

  // Channel count and fixed field widths
  localparam int CHANNELS  = 2;
  localparam int ANGLE_W   = 12;
  localparam int TIMER_W   = 24;
  localparam int TURN_W    = 24;
  localparam int POS_W     = TURN_W + ANGLE_W;   // turns * 4096 + raw
  localparam int DMAG_W    = POS_W + 1;          // magnitude of a position change
  localparam int VEL_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Multiply split: low and high slices of the position change
  localparam int LO_W      = 19;
  localparam int PP_LO_W   = LO_W + TIMER_W;
  localparam int PP_HI_W   = DMAG_W - LO_W + TIMER_W;
  localparam int PROD_W    = DMAG_W + TIMER_W;

  // Divider: two quotient bits per cycle
  localparam int DIV_STEPS = (PROD_W + 1) / 2;
  localparam int DIVD_W    = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [TIMER_W-1:0] TIMER_MASK = {TIMER_W{1'b1}};
  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

  localparam logic [DIVD_W-1:0] VEL_POS_LIM = DIVD_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [DIVD_W-1:0] VEL_NEG_LIM = DIVD_W'(64'h0000_0000_8000_0000);
  localparam logic [VEL_W-1:0]  VEL_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0]  VEL_NEG_SAT = 32'h8000_0000;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE_HZ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 2'd2;

  localparam logic [ANGLE_W-1:0] WRAP_THRESHOLD_RST = 12'd3276;
  localparam logic [TIMER_W-1:0] TICK_RATE_RST      = 24'd9000000;
  localparam logic [TIMER_W-1:0] MIN_INTERVAL_RST   = 24'd900;

  // One classified item handed from front to back
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    vel_en;
    logic                    neg;
    logic [DMAG_W-1:0]       dmag;
    logic [TIMER_W-1:0]      interval;
    logic                    clamped;
  } job_t;

endpackage

// ===== rtl/core/encoder_multiturn_velocity.sv =====
// Front: capture (F_IDLE), turn and interval update (F_TURN), hand-off to the
// queue (F_DIFF, held while it is full); a new item is taken only after hand-off.
// Back: a velocity item passes B_MUL, B_SUM and the 2-bit-per-cycle divider B_DIV
// to B_DONE, a position-only item goes straight to B_DONE; both wait on the output.
// Reset (rst_n low, synchronous): channel state cleared, registers to defaults.
module encoder_multiturn_velocity import emv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic                    in_channel,
  input  logic [ANGLE_W-1:0]      in_raw_angle,
  input  logic [TIMER_W-1:0]      in_timer_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_position,
  output logic signed [VEL_W-1:0] out_velocity,
  output logic                    out_interval_clamped,
  output logic                    out_velocity_saturated,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [TIMER_W-1:0]      cfg_data
);

  // Configuration registers. A write lands at once; write them only while
  // no item is in flight, so no item sees a register change halfway through.
  logic [ANGLE_W-1:0] wrap_threshold_r;
  logic [TIMER_W-1:0] tick_rate_hz_r;
  logic [TIMER_W-1:0] min_interval_r;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_threshold_r <= WRAP_THRESHOLD_RST;
      tick_rate_hz_r   <= TICK_RATE_RST;
      min_interval_r   <= MIN_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WRAP_THRESHOLD: wrap_threshold_r <= cfg_data[ANGLE_W-1:0];
        REG_TICK_RATE_HZ:   tick_rate_hz_r   <= cfg_data;
        REG_MIN_INTERVAL:   min_interval_r   <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: capture the item, advance the channel's turn count, measure the
  // timer interval and the position change, then hand a job to the queue.
  // All per-channel state is updated here, so the next item of the same
  // channel already sees it while the back is still dividing.
  emv_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_channel         (in_channel),
    .in_raw_angle       (in_raw_angle),
    .in_timer_value     (in_timer_value),
    .wrap_threshold     (wrap_threshold_r),
    .min_interval_ticks (min_interval_r),
    .push               (push),
    .push_job           (push_job),
    .q_full             (q_full)
  );

  // Short queue: lets the front take new items while the back divides.
  emv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Back: for a velocity item, change times tick rate (two partial products, then a sum),
  // divide by the interval two bits a cycle and saturate; hold every result in the output
  // register until the consumer takes it.
  emv_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .pop                    (pop),
    .pop_job                (pop_job),
    .tick_rate_hz           (tick_rate_hz_r),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_position           (out_position),
    .out_velocity           (out_velocity),
    .out_interval_clamped   (out_interval_clamped),
    .out_velocity_saturated (out_velocity_saturated)
  );

endmodule

// ===== rtl/core/emv_queue.sv =====
module emv_queue import emv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/emv_front.sv =====
module emv_front import emv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic               in_channel,
  input  logic [ANGLE_W-1:0] in_raw_angle,
  input  logic [TIMER_W-1:0] in_timer_value,
  input  logic [ANGLE_W-1:0] wrap_threshold,
  input  logic [TIMER_W-1:0] min_interval_ticks,
  output logic               push,
  output job_t               push_job,
  input  logic               q_full
);

  typedef enum logic [1:0] {F_IDLE, F_TURN, F_DIFF} fstate_t;

  fstate_t state_r;

  // Captured item
  logic               mode_r;
  logic               chan_r;
  logic [ANGLE_W-1:0] raw_r;
  logic [TIMER_W-1:0] timer_r;

  // Results of the turn step
  logic signed [TURN_W-1:0] turn_new_r;
  logic [TIMER_W-1:0]       interval_r;
  logic                     clamped_r;

  // Per-channel tracking state
  logic [ANGLE_W-1:0]       last_raw_r  [CHANNELS];
  logic signed [TURN_W-1:0] turn_r      [CHANNELS];
  logic [TIMER_W-1:0]       last_timer_r[CHANNELS];
  logic signed [POS_W-1:0]  last_pos_r  [CHANNELS];

  logic                     ch_ok;
  logic signed [ANGLE_W:0]  jump;
  logic [ANGLE_W-1:0]       jump_mag;
  logic                     wrap;
  logic signed [TURN_W-1:0] turn_nxt;
  logic [TIMER_W-1:0]       ivl_raw;
  logic                     clamp_nxt;
  logic [TIMER_W-1:0]       interval_nxt;
  logic signed [POS_W-1:0]  position;
  logic signed [DMAG_W-1:0] dv;
  logic [DMAG_W-1:0]        dmag;

  assign ch_ok    = (int'(chan_r) < CHANNELS);
  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_DIFF) && !q_full;

  // Turn tracking and timer interval
  always_comb begin
    jump     = $signed({1'b0, raw_r}) - $signed({1'b0, last_raw_r[chan_r]});
    jump_mag = jump[ANGLE_W] ? ANGLE_W'(-jump) : jump[ANGLE_W-1:0];
    wrap     = (jump_mag > wrap_threshold);
    turn_nxt = turn_r[chan_r];
    if (wrap && !jump[ANGLE_W]) begin
      if (turn_r[chan_r] != TURN_MIN) turn_nxt = turn_r[chan_r] - 1'b1;
    end else if (wrap) begin
      if (turn_r[chan_r] != TURN_MAX) turn_nxt = turn_r[chan_r] + 1'b1;
    end

    if (timer_r < last_timer_r[chan_r]) begin
      ivl_raw = last_timer_r[chan_r] - timer_r;
    end else begin
      ivl_raw = (TIMER_MASK - timer_r) + last_timer_r[chan_r];
    end
    clamp_nxt    = (ivl_raw < min_interval_ticks);
    interval_nxt = clamp_nxt ? min_interval_ticks : ivl_raw;
    if (interval_nxt == '0) interval_nxt = TIMER_W'(1);
  end

  // Position and change since the last velocity update
  always_comb begin
    position = $signed({turn_new_r, raw_r});
    dv       = $signed({position[POS_W-1], position})
             - $signed({last_pos_r[chan_r][POS_W-1], last_pos_r[chan_r]});
    dmag     = dv[DMAG_W-1] ? DMAG_W'(-dv) : DMAG_W'(dv);

    push_job = '0;
    if (ch_ok) begin
      push_job.position = position;
      push_job.vel_en   = mode_r;
      push_job.neg      = dv[DMAG_W-1];
      push_job.dmag     = dmag;
      push_job.interval = interval_r;
      push_job.clamped  = mode_r & clamped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        last_raw_r[i]   <= '0;
        turn_r[i]       <= '0;
        last_timer_r[i] <= '0;
        last_pos_r[i]   <= '0;
      end
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            chan_r  <= in_channel;
            raw_r   <= in_raw_angle;
            timer_r <= in_timer_value;
            state_r <= F_TURN;
          end
        end
        F_TURN: begin
          turn_new_r <= turn_nxt;
          interval_r <= interval_nxt;
          clamped_r  <= clamp_nxt;
          if (ch_ok) begin
            last_raw_r[chan_r] <= raw_r;
            turn_r[chan_r]     <= turn_nxt;
          end
          state_r <= F_DIFF;
        end
        F_DIFF: begin
          if (!q_full) begin
            if (ch_ok && mode_r) begin
              last_timer_r[chan_r] <= timer_r;
              last_pos_r[chan_r]   <= position;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/emv_back.sv =====
module emv_back import emv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  output logic                    pop,
  input  job_t                    pop_job,
  input  logic [TIMER_W-1:0]      tick_rate_hz,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_position,
  output logic signed [VEL_W-1:0] out_velocity,
  output logic                    out_interval_clamped,
  output logic                    out_velocity_saturated
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUM, B_DIV, B_DONE} bstate_t;

  bstate_t state_r;
  job_t    job_r;

  logic [PP_LO_W-1:0] pp_lo_r;
  logic [PP_HI_W-1:0] pp_hi_r;
  logic [DIVD_W-1:0]  dq_r;
  logic [TIMER_W-1:0] rem_r;
  logic [DCNT_W-1:0]  cnt_r;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_position_r;
  logic signed [VEL_W-1:0] out_velocity_r;
  logic                    out_clamped_r;
  logic                    out_sat_r;

  logic [TIMER_W:0]   s1;
  logic [TIMER_W:0]   s2;
  logic [DIVD_W-1:0]  dq_nxt;
  logic [TIMER_W-1:0] rem_nxt;
  logic [PROD_W-1:0]  prod;
  logic [VEL_W-1:0]   vel_nxt;
  logic               sat_nxt;
  logic               out_free;
  logic               out_load;

  // One restoring step: {quotient bit, remainder}
  function automatic logic [TIMER_W:0] div_step(input logic [TIMER_W-1:0] rem,
                                                input logic b,
                                                input logic [TIMER_W-1:0] d);
    logic [TIMER_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, TIMER_W'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[TIMER_W-1:0]};
    end
  endfunction

  assign pop      = (state_r == B_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == B_DONE) && out_free;

  always_comb begin
    s1      = div_step(rem_r, dq_r[DIVD_W-1], job_r.interval);
    s2      = div_step(s1[TIMER_W-1:0], dq_r[DIVD_W-2], job_r.interval);
    rem_nxt = s2[TIMER_W-1:0];
    dq_nxt  = {dq_r[DIVD_W-3:0], s1[TIMER_W], s2[TIMER_W]};
    prod    = PROD_W'(pp_lo_r) + (PROD_W'(pp_hi_r) << LO_W);
  end

  // Saturate the quotient to the signed 32-bit range
  always_comb begin
    vel_nxt = '0;
    sat_nxt = 1'b0;
    if (job_r.vel_en) begin
      if (job_r.neg) begin
        if (dq_r > VEL_NEG_LIM) begin
          vel_nxt = VEL_NEG_SAT;
          sat_nxt = 1'b1;
        end else begin
          vel_nxt = VEL_W'(-dq_r[VEL_W-1:0]);
        end
      end else begin
        if (dq_r > VEL_POS_LIM) begin
          vel_nxt = VEL_POS_SAT;
          sat_nxt = 1'b1;
        end else begin
          vel_nxt = dq_r[VEL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r   <= pop_job;
            state_r <= pop_job.vel_en ? B_MUL : B_DONE;
          end
        end
        B_MUL: begin
          pp_lo_r <= job_r.dmag[LO_W-1:0] * tick_rate_hz;
          pp_hi_r <= job_r.dmag[DMAG_W-1:LO_W] * tick_rate_hz;
          state_r <= B_SUM;
        end
        B_SUM: begin
          dq_r    <= DIVD_W'(prod);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DCNT_W'(DIV_STEPS - 1)) state_r <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_position_r <= job_r.position;
            out_velocity_r <= vel_nxt;
            out_clamped_r  <= job_r.clamped;
            out_sat_r      <= sat_nxt;
            state_r        <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_position           = out_position_r;
  assign out_velocity           = out_velocity_r;
  assign out_interval_clamped   = out_clamped_r;
  assign out_velocity_saturated = out_sat_r;

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_velocity_r == VEL_POS_SAT || out_velocity_r == VEL_NEG_SAT))
    else $error("saturation flag without limit velocity");

endmodule

// ===== test/encoder_multiturn_velocity_tb.sv =====
module encoder_multiturn_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import emv_pkg::*;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int DRAIN_PAUSE     = 50;    // time for stray results after the drain

  // One result item as the block should present it
  typedef struct {
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
    logic                    clamped;
    logic                    saturated;
  } reading_t;

  // One row of the directed table: a register write or an input item, the latter
  // optionally carrying a hand-typed expectation
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [TIMER_W-1:0]   reg_val;
    logic                 mode;
    logic                 channel;
    logic [ANGLE_W-1:0]   angle;
    logic [TIMER_W-1:0]   timer;
    bit                   known;
    reading_t             want;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic                    in_channel;
  logic [ANGLE_W-1:0]      in_raw_angle;
  logic [TIMER_W-1:0]      in_timer_value;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic signed [VEL_W-1:0] out_velocity;
  logic                    out_interval_clamped;
  logic                    out_velocity_saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [TIMER_W-1:0]      cfg_data;

  // Tracker copy: registers and per-channel state, updated in input order
  logic [ANGLE_W-1:0]      wrap_thr;
  logic [TIMER_W-1:0]      tick_rate;
  logic [TIMER_W-1:0]      min_ticks;
  logic [ANGLE_W-1:0]      prev_angle   [CHANNELS];
  logic signed [TURN_W-1:0] turns       [CHANNELS];
  logic [TIMER_W-1:0]      prev_timer   [CHANNELS];
  logic signed [POS_W-1:0] vel_base_pos [CHANNELS];

  reading_t expected_readings[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       stall_left     = 0;
  bit       gap_on         = 1'b1;
  bit       stall_on       = 1'b1;

  encoder_multiturn_velocity i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one sample and advance the tracked channel state.
  function automatic reading_t track_sample(logic m, logic c, logic [ANGLE_W-1:0] ang,
                                            logic [TIMER_W-1:0] tmr);
    reading_t            r;
    int                  jump;
    int                  mag;
    logic [TIMER_W-1:0]  span;
    longint              dv;
    longint unsigned     dmag;
    longint unsigned     q;
    bit                  neg;
    r = '{'0, '0, 1'b0, 1'b0};
    jump = int'(ang) - int'(prev_angle[c]);
    mag  = (jump < 0) ? -jump : jump;
    // A jump past the threshold is a zero crossing: forward jump means we went
    // backwards through zero, so count a turn down; hold at the turn limits.
    if (mag > int'(wrap_thr)) begin
      if (jump > 0) begin
        if (turns[c] != TURN_MIN) turns[c] = turns[c] - 1'b1;
      end else begin
        if (turns[c] != TURN_MAX) turns[c] = turns[c] + 1'b1;
      end
    end
    prev_angle[c] = ang;
    r.position = {turns[c], ang};  // turns * 4096 + raw
    if (m) begin
      // Down-counter: equal or higher sample means one full wrap went by
      if (tmr < prev_timer[c]) span = prev_timer[c] - tmr;
      else span = TIMER_MASK - tmr + prev_timer[c];
      if (span < min_ticks) begin
        span = min_ticks;
        r.clamped = 1'b1;
      end
      if (span == 0) span = TIMER_W'(1);
      dv   = longint'(r.position) - longint'(vel_base_pos[c]);
      neg  = dv < 0;
      dmag = neg ? -dv : dv;
      q    = dmag * tick_rate / span;
      if (neg) begin
        if (q > 64'd2147483648) begin
          q = 64'd2147483648;
          r.saturated = 1'b1;
        end
        r.velocity = 32'(64'd0 - q);
      end else begin
        if (q > 64'd2147483647) begin
          q = 64'd2147483647;
          r.saturated = 1'b1;
        end
        r.velocity = 32'(q);
      end
      prev_timer[c]   = tmr;
      vel_base_pos[c] = r.position;
    end
    return r;
  endfunction

  function automatic plan_row_t sample_row(logic m, logic c, int a, int t);
    plan_row_t row;
    row.is_reg  = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.mode    = m;
    row.channel = c;
    row.angle   = ANGLE_W'(a);
    row.timer   = TIMER_W'(t);
    row.known   = 1'b0;
    row.want    = '{'0, '0, 1'b0, 1'b0};
    return row;
  endfunction

  function automatic plan_row_t known_row(logic m, logic c, int a, int t, longint pos,
                                          longint vel, bit cl, bit sat);
    plan_row_t row;
    row = sample_row(m, c, a, t);
    row.known = 1'b1;
    row.want  = '{POS_W'(pos), VEL_W'(vel), cl, sat};
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t row;
    row = sample_row(1'b0, 1'b0, 0, 0);
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = TIMER_W'(val);
    return row;
  endfunction

  task automatic flag_mismatch(string field, longint want, longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Write one register and mirror it; leave cfg_valid high for a following write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WRAP_THRESHOLD: wrap_thr  = val[ANGLE_W-1:0];
      REG_TICK_RATE_HZ:   tick_rate = val;
      REG_MIN_INTERVAL:   min_ticks = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [ANGLE_W-1:0] w, logic [TIMER_W-1:0] t,
                           logic [TIMER_W-1:0] mn);
    write_reg(REG_WRAP_THRESHOLD, TIMER_W'(w));
    write_reg(REG_TICK_RATE_HZ, t);
    write_reg(REG_MIN_INTERVAL, mn);
    cfg_valid <= 1'b0;
  endtask

  // Present one item, hold it until taken, then queue what it should produce.
  // Valid stays high afterwards so back-to-back items need no re-raise.
  task automatic feed_sample(logic m, logic c, logic [ANGLE_W-1:0] ang,
                             logic [TIMER_W-1:0] tmr, bit known, reading_t want);
    reading_t r;
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_channel     <= c;
    in_raw_angle   <= ang;
    in_timer_value <= tmr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = track_sample(m, c, ang, tmr);
    expected_readings.push_back(known ? want : r);
  endtask

  // Occasional random sender gap, only while gap_on is set
  task automatic idle_input();
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Every item yields exactly one result, so an empty queue means the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // Receiver stall: random bursts; no new burst starts when stall_on is cleared
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expectation, field by field
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        flag_mismatch("unexpected result, position", 0, out_position);
      end else begin
        want = expected_readings.pop_front();
        if (out_position !== want.position)
          flag_mismatch("position", want.position, out_position);
        if (out_velocity !== want.velocity)
          flag_mismatch("velocity", want.velocity, out_velocity);
        if (out_interval_clamped !== want.clamped)
          flag_mismatch("interval_clamped", want.clamped, out_interval_clamped);
        if (out_velocity_saturated !== want.saturated)
          flag_mismatch("velocity_saturated", want.saturated, out_velocity_saturated);
      end
    end
  end

  // Stop a hung run: count cycles in which no channel moves anything
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("encoder_multiturn_velocity verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t          plan[$];
    reading_t           none;
    logic               m;
    logic               c;
    logic [ANGLE_W-1:0] ang;
    logic [TIMER_W-1:0] tmr;
    logic [ANGLE_W-1:0] stim_angle[CHANNELS];
    logic [TIMER_W-1:0] stim_timer[CHANNELS];
    int                 step;
    int                 span;
    bit                 busy;

    // Drive every input to a known value before the first edge
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= 1'b0;
    in_channel     <= 1'b0;
    in_raw_angle   <= '0;
    in_timer_value <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;

    // Tracker starts from the reset state
    wrap_thr  = WRAP_THRESHOLD_RST;
    tick_rate = TICK_RATE_RST;
    min_ticks = MIN_INTERVAL_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      prev_angle[i]   = '0;
      turns[i]        = '0;
      prev_timer[i]   = '0;
      vel_base_pos[i] = '0;
      stim_angle[i]   = '0;
      stim_timer[i]   = '0;
    end
    none = '{'0, '0, 1'b0, 1'b0};
    busy = 1'b0;

    // Directed table. Reset defaults first: wrap both ways, a clamped first
    // velocity, a timer wrap, then threshold boundary on channel 0.
    plan.push_back(known_row(1'b0, 1'b0, 0,    0,        0,     0,       1'b0, 1'b0));
    plan.push_back(known_row(1'b0, 1'b0, 4095, 0,        -1,    0,       1'b0, 1'b0));
    plan.push_back(known_row(1'b0, 1'b0, 0,    0,        0,     0,       1'b0, 1'b0));
    plan.push_back(known_row(1'b1, 1'b1, 100,  24'hFFFFFF, 100, 1000000, 1'b1, 1'b0));
    plan.push_back(known_row(1'b1, 1'b1, 100,  16768215, 100,   0,       1'b0, 1'b0));
    plan.push_back(known_row(1'b1, 1'b1, 4095, 7768215,  -1,    -101,    1'b0, 1'b0));
    plan.push_back(known_row(1'b0, 1'b1, 2048, 0,        -2048, 0,       1'b0, 1'b0));
    plan.push_back(sample_row(1'b1, 1'b0, 3276, 0));   // jump equal to threshold
    plan.push_back(sample_row(1'b0, 1'b0, 0,    0));
    plan.push_back(known_row(1'b0, 1'b0, 3277, 0,        -819,  0,       1'b0, 1'b0));
    // Fastest tick rate over a one-tick interval: saturate both ways
    plan.push_back(reg_row(REG_MIN_INTERVAL, 1));
    plan.push_back(reg_row(REG_TICK_RATE_HZ, 24'hFFFFFF));
    plan.push_back(known_row(1'b1, 1'b1, 2048, 7768214, -2048, -64'sd2147483648, 1'b0, 1'b1));
    plan.push_back(known_row(1'b1, 1'b1, 3000, 7768213, -1096, 2147483647,       1'b0, 1'b1));
    // No minimum: equal timer gives a full wrap; full-scale timer after zero
    // gives a zero interval that is forced to one
    plan.push_back(reg_row(REG_MIN_INTERVAL, 0));
    plan.push_back(known_row(1'b1, 1'b1, 3000, 7768213, -1096, 0, 1'b0, 1'b0));
    plan.push_back(known_row(1'b1, 1'b0, 3277, 24'hFFFFFF, -819, -64'sd2147483648, 1'b0, 1'b1));
    // Zero tick rate: velocity stays zero
    plan.push_back(reg_row(REG_TICK_RATE_HZ, 0));
    plan.push_back(known_row(1'b1, 1'b0, 100,  24'h800000, -3996, 0, 1'b0, 1'b0));
    plan.push_back(sample_row(1'b1, 1'b1, 4095, 0));
    // Threshold extremes: every nonzero jump wraps, then no jump wraps
    plan.push_back(reg_row(REG_WRAP_THRESHOLD, 0));
    plan.push_back(known_row(1'b0, 1'b0, 101,  0,        -8091, 0,       1'b0, 1'b0));
    plan.push_back(sample_row(1'b0, 1'b0, 101,  0));
    plan.push_back(reg_row(REG_WRAP_THRESHOLD, 4095));
    plan.push_back(sample_row(1'b0, 1'b0, 4095, 0));
    plan.push_back(sample_row(1'b0, 1'b0, 0,    24'hFFFFFF));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table; let the block go idle before any register write
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (busy) begin
          drain_results();
          busy = 1'b0;
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        feed_sample(plan[i].mode, plan[i].channel, plan[i].angle, plan[i].timer,
                    plan[i].known, plan[i].want);
        busy = 1'b1;
        idle_input();
      end
    end

    // Random phases, each loading its register setting first. The last phase runs
    // without any idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: load_regs(WRAP_THRESHOLD_RST, TICK_RATE_RST, MIN_INTERVAL_RST);
        1: load_regs(12'd4095, TIMER_MASK, TIMER_MASK);
        2: load_regs(12'd0, 24'd1, 24'd1);
        3: load_regs(ANGLE_W'($urandom_range(0, 4095)),
                     TIMER_W'($urandom_range(1, 24'hFFFFFF)),
                     TIMER_W'($urandom_range(1, 5000)));
        4: load_regs(ANGLE_W'($urandom_range(1000, 4095)), TIMER_MASK, 24'd1);
        5: load_regs(ANGLE_W'($urandom), TIMER_W'($urandom), TIMER_W'($urandom));
        default: load_regs(WRAP_THRESHOLD_RST, TICK_RATE_RST, MIN_INTERVAL_RST);
      endcase
      if (p == PHASES - 1) begin
        gap_on   = 1'b0;
        stall_on = 1'b0;
      end else begin
        gap_on   = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end

      repeat (ITEMS_PER_PHASE) begin
        c = 1'($urandom_range(0, 1));
        m = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            // Plausible motion: small angle step, timer counts down a while
            step = int'($urandom_range(0, 1200)) - 600;
            ang  = stim_angle[c] + ANGLE_W'(step);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
                                               : $urandom_range(1, 300000);
            tmr  = stim_timer[c] - TIMER_W'(span);
          end
          7: begin
            // Random angle jump over a short interval
            ang = ANGLE_W'($urandom);
            tmr = stim_timer[c] - TIMER_W'($urandom_range(0, 5000));
          end
          8: begin
            ang = $urandom_range(0, 1) ? '1 : '0;
            tmr = $urandom_range(0, 1) ? '1 : '0;
          end
          default: begin
            ang = ANGLE_W'($urandom);
            tmr = TIMER_W'($urandom);
          end
        endcase
        stim_angle[c] = ang;
        stim_timer[c] = tmr;
        feed_sample(m, c, ang, tmr, 1'b0, none);
        idle_input();
      end
    end

    // Wait out every expected result, then give stray results time to show up
    drain_results();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("encoder_multiturn_velocity verification clean");
    end else begin
      $display("encoder_multiturn_velocity verification failed");
    end
    $finish;
  end

endmodule
